### rtl/wvm_pkg.sv
// ----------------------------------------------------------------------------
// wvm_pkg: shared types and tables of the wavetable voice mixer
// Request and result structs, command and register codes, pitch step and
// fade tables.
// ----------------------------------------------------------------------------
`default_nettype none

package wvm_pkg;

    localparam int VOICE_COUNT_DEF   = 6;
    localparam int BUFFER_LENGTH_DEF = 32;
    localparam int WAVE_DEPTH_DEF    = 4096;

    localparam int KEY_MAX   = 107;
    localparam int MIX_LIMIT = 255;
    localparam int FRAC_BITS = 16;

    localparam logic [1:0] CMD_NOTE   = 2'd0;
    localparam logic [1:0] CMD_SAMPLE = 2'd1;
    localparam logic [1:0] CMD_WAVE   = 2'd2;

    localparam logic REG_ATTACK  = 1'b0;
    localparam logic REG_SUSTAIN = 1'b1;

    typedef struct packed {
        logic [1:0]         command;
        logic [3:0]         note_channel;
        logic [6:0]         note_key;
        logic [6:0]         note_velocity;
        logic [11:0]        wave_address;
        logic signed [15:0] wave_value;
    } cmd_t;

    typedef struct packed {
        logic signed [8:0] mixed_sample;
        logic              silent;
    } smp_t;

    // 5.16 phase step for each key
    localparam logic [20:0] STEP_ROM [0:KEY_MAX] = '{
        21'd4286, 21'd4540, 21'd4810, 21'd5099, 21'd5400, 21'd5723, 21'd6061,
        21'd6423, 21'd6805, 21'd7209, 21'd7639, 21'd8092, 21'd8572, 21'd9083,
        21'd9623, 21'd10195, 21'd10800, 21'd11443, 21'd12124, 21'd12845,
        21'd13608, 21'd14418, 21'd15275, 21'd16185, 21'd17147, 21'd18167,
        21'd19247, 21'd20390, 21'd21603, 21'd22888, 21'd24248, 21'd25690,
        21'd27218, 21'd28836, 21'd30550, 21'd32367, 21'd34291, 21'd36331,
        21'd38491, 21'd40779, 21'd43204, 21'd45773, 21'd48497, 21'd51380,
        21'd54434, 21'd57672, 21'd61101, 21'd64734, 21'd68585, 21'd72661,
        21'd76981, 21'd81561, 21'd86411, 21'd91549, 21'd96991, 21'd102760,
        21'd108868, 21'd115343, 21'd122201, 21'd129468, 21'd137167,
        21'd145325, 21'd153965, 21'd163119, 21'd172818, 21'd183097,
        21'd193984, 21'd205518, 21'd217739, 21'd230687, 21'd244405,
        21'd258938, 21'd274334, 21'd290647, 21'd307930, 21'd326241,
        21'd345639, 21'd366192, 21'd387968, 21'd411037, 21'd435479,
        21'd461373, 21'd488809, 21'd517873, 21'd548667, 21'd581294,
        21'd615860, 21'd652482, 21'd691279, 21'd732386, 21'd775936,
        21'd822073, 21'd870958, 21'd922747, 21'd977616, 21'd1035749,
        21'd1097337, 21'd1162588, 21'd1231718, 21'd1304961, 21'd1382558,
        21'd1464769, 21'd1551869, 21'd1644149, 21'd1741915, 21'd1845494,
        21'd1955232, 21'd2071496
    };

    // envelope gain for each decay step
    localparam logic [7:0] FADE_ROM [0:255] = '{
        8'd255, 8'd252, 8'd250, 8'd247, 8'd245, 8'd243, 8'd240, 8'd238,
        8'd235, 8'd233, 8'd231, 8'd228, 8'd226, 8'd224, 8'd222, 8'd219,
        8'd217, 8'd215, 8'd213, 8'd211, 8'd209, 8'd207, 8'd205, 8'd203,
        8'd201, 8'd199, 8'd197, 8'd195, 8'd193, 8'd191, 8'd189, 8'd187,
        8'd185, 8'd183, 8'd182, 8'd180, 8'd178, 8'd176, 8'd174, 8'd173,
        8'd171, 8'd169, 8'd168, 8'd166, 8'd164, 8'd163, 8'd161, 8'd159,
        8'd158, 8'd156, 8'd155, 8'd153, 8'd152, 8'd150, 8'd149, 8'd147,
        8'd146, 8'd144, 8'd143, 8'd141, 8'd140, 8'd139, 8'd137, 8'd136,
        8'd134, 8'd133, 8'd132, 8'd130, 8'd129, 8'd128, 8'd127, 8'd125,
        8'd124, 8'd123, 8'd122, 8'd120, 8'd119, 8'd118, 8'd117, 8'd116,
        8'd115, 8'd113, 8'd112, 8'd111, 8'd110, 8'd109, 8'd108, 8'd107,
        8'd106, 8'd105, 8'd104, 8'd103, 8'd102, 8'd101, 8'd100, 8'd99,
        8'd98, 8'd97, 8'd96, 8'd95, 8'd94, 8'd93, 8'd92, 8'd91,
        8'd90, 8'd89, 8'd88, 8'd87, 8'd87, 8'd86, 8'd85, 8'd84,
        8'd83, 8'd82, 8'd82, 8'd81, 8'd80, 8'd79, 8'd78, 8'd78,
        8'd77, 8'd76, 8'd75, 8'd75, 8'd74, 8'd73, 8'd72, 8'd72,
        8'd71, 8'd70, 8'd69, 8'd69, 8'd68, 8'd67, 8'd67, 8'd66,
        8'd65, 8'd65, 8'd64, 8'd64, 8'd63, 8'd62, 8'd62, 8'd61,
        8'd60, 8'd60, 8'd59, 8'd59, 8'd58, 8'd57, 8'd57, 8'd56,
        8'd56, 8'd55, 8'd55, 8'd54, 8'd54, 8'd53, 8'd53, 8'd52,
        8'd51, 8'd51, 8'd50, 8'd50, 8'd49, 8'd49, 8'd48, 8'd48,
        8'd48, 8'd47, 8'd47, 8'd46, 8'd46, 8'd45, 8'd45, 8'd44,
        8'd44, 8'd43, 8'd43, 8'd43, 8'd42, 8'd42, 8'd41, 8'd40,
        8'd40, 8'd39, 8'd39, 8'd38, 8'd38, 8'd37, 8'd37, 8'd36,
        8'd35, 8'd35, 8'd34, 8'd34, 8'd33, 8'd33, 8'd32, 8'd31,
        8'd31, 8'd30, 8'd30, 8'd29, 8'd29, 8'd28, 8'd28, 8'd27,
        8'd26, 8'd26, 8'd25, 8'd25, 8'd24, 8'd24, 8'd23, 8'd22,
        8'd22, 8'd21, 8'd21, 8'd20, 8'd20, 8'd19, 8'd19, 8'd18,
        8'd17, 8'd17, 8'd16, 8'd16, 8'd15, 8'd15, 8'd14, 8'd13,
        8'd13, 8'd12, 8'd12, 8'd11, 8'd11, 8'd10, 8'd10, 8'd9,
        8'd8, 8'd8, 8'd7, 8'd7, 8'd6, 8'd6, 8'd5, 8'd4,
        8'd4, 8'd3, 8'd3, 8'd2, 8'd2, 8'd1, 8'd1, 8'd0
    };

endpackage

`default_nettype wire

### rtl/wavetable_voice_mixer.sv
// ----------------------------------------------------------------------------
// wavetable_voice_mixer: multi-voice wavetable synthesiser with mixing
// Note, wave-write and sample requests; one clamped mixed sample per sample
// request, produced by a voice-serial sequencer around one shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

// Note and wave-write requests are taken whenever the sequencer is idle and
// give no result. A sample request walks the voices one after another: an idle
// voice is skipped in the read state, an active voice passes through a wave
// memory read, two passes through the single shared multiplier for velocity
// and fade gain, and an accumulate; a final state then scales and clamps the
// sum. A sample request holds the request channel stalled from when it is
// taken until its result is registered, longer while a previous result is
// still waiting on a stalled result channel. The wave memory needs no clearing.
module wavetable_voice_mixer #(
    parameter int VOICE_COUNT   = wvm_pkg::VOICE_COUNT_DEF,
    parameter int BUFFER_LENGTH = wvm_pkg::BUFFER_LENGTH_DEF,
    parameter int WAVE_DEPTH    = wvm_pkg::WAVE_DEPTH_DEF
) (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          cmd_valid,
    output logic         cmd_stall,
    input  wire wvm_pkg::cmd_t cmd_data,
    output logic         smp_valid,
    input  wire          smp_stall,
    output wvm_pkg::smp_t smp_data,
    input  wire          cfg_write,
    input  wire          cfg_index,
    input  wire  [11:0]  cfg_data
);

    localparam int VI_W  = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int CNT_W = (BUFFER_LENGTH > 1) ? $clog2(BUFFER_LENGTH) : 1;
    localparam int AW    = $clog2(WAVE_DEPTH);
    localparam int ACC_W = 33 + $clog2(VOICE_COUNT);
    localparam int FB    = wvm_pkg::FRAC_BITS;

    localparam logic [VI_W-1:0]  LAST_VOICE = VI_W'(VOICE_COUNT - 1);
    localparam logic [CNT_W-1:0] LAST_SLOT  = CNT_W'(BUFFER_LENGTH - 1);
    localparam logic [6:0]       KEY_SAT    = 7'(wvm_pkg::KEY_MAX);
    localparam logic signed [ACC_W-1:0] Q_MAX = ACC_W'(wvm_pkg::MIX_LIMIT);
    localparam logic signed [ACC_W-1:0] Q_MIN = -Q_MAX;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MUL1,
        S_MUL2,
        S_ACC,
        S_DONE
    } state_t;

    state_t state_reg;

    logic [11:0] attack_reg;
    logic [11:0] sustain_reg;

    logic [3:0]  chan_reg  [VOICE_COUNT];
    logic [6:0]  key_reg   [VOICE_COUNT];
    logic [6:0]  vel_reg   [VOICE_COUNT];
    logic [8:0]  decay_reg [VOICE_COUNT];
    logic [31:0] pos_reg   [VOICE_COUNT];

    logic [CNT_W-1:0] slot_reg;
    logic             phase_reg;

    logic [VI_W-1:0]          voice_reg;
    logic                     silent_reg;
    logic [31:0]              pos_sum_reg;
    logic signed [32:0]       prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    logic                     out_valid_reg;
    wvm_pkg::smp_t            out_data_reg;

    logic signed [15:0] wave_mem [WAVE_DEPTH];
    logic signed [15:0] mem_q_reg;

    // ------------------------------------------------------------------
    // request decode
    // ------------------------------------------------------------------
    logic cmd_take;
    logic note_on;
    logic note_off;
    logic wave_we;
    logic smp_start;
    logic [VI_W-1:0] note_voice;

    assign cmd_stall = (state_reg != S_IDLE);
    assign cmd_take  = cmd_valid && !cmd_stall;
    assign note_on   = cmd_take && (cmd_data.command == wvm_pkg::CMD_NOTE)
                       && (cmd_data.note_velocity != 7'd0);
    assign note_off  = cmd_take && (cmd_data.command == wvm_pkg::CMD_NOTE)
                       && (cmd_data.note_velocity == 7'd0);
    assign wave_we   = cmd_take && (cmd_data.command == wvm_pkg::CMD_WAVE);
    assign smp_start = cmd_take && (cmd_data.command == wvm_pkg::CMD_SAMPLE);

    // channel to voice: table built at elaboration
    always_comb
    begin
        note_voice = '0;
        for (int i = 0; i < 16; i++)
        begin
            if (cmd_data.note_channel == 4'(i))
            begin
                note_voice = VI_W'(i % VOICE_COUNT);
            end
        end
    end

    // ------------------------------------------------------------------
    // per-voice arithmetic
    // ------------------------------------------------------------------
    logic [6:0]  cur_key_sat;
    logic [31:0] cur_step;
    logic [7:0]  cur_fade;
    logic [12:0] loop_end;
    logic [31:0] limit;
    logic [31:0] loop_len;
    logic        wrap;
    logic [8:0]  decay_nx;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;

    assign cur_key_sat = (key_reg[voice_reg] > KEY_SAT) ? KEY_SAT : key_reg[voice_reg];
    assign cur_step    = 32'(wvm_pkg::STEP_ROM[cur_key_sat]);
    assign cur_fade    = wvm_pkg::FADE_ROM[decay_reg[voice_reg][7:0]];
    assign loop_end    = {1'b0, attack_reg} + {1'b0, sustain_reg};
    assign limit       = {3'b000, loop_end, 16'h0000};
    assign loop_len    = {4'h0, sustain_reg, 16'h0000};
    assign wrap        = (pos_sum_reg > limit);
    assign decay_nx    = decay_reg[voice_reg] + {8'h00, (wrap && !phase_reg)};
    assign rd_addr     = pos_reg[voice_reg][FB +: AW];
    assign wr_addr     = AW'(cmd_data.wave_address);

    // shared multiplier: wave * velocity, then that product * fade gain
    logic signed [23:0] mul_a;
    logic signed [8:0]  mul_b;
    logic signed [32:0] mul_p;

    always_comb
    begin
        if (state_reg == S_MUL1)
        begin
            mul_a = {{8{mem_q_reg[15]}}, mem_q_reg};
            mul_b = $signed({2'b00, vel_reg[voice_reg]});
        end
        else
        begin
            mul_a = $signed(prod_reg[23:0]);
            mul_b = $signed({1'b0, cur_fade});
        end
    end

    assign mul_p = mul_a * mul_b;

    // scale and clamp
    logic signed [ACC_W-1:0] q_raw;
    logic signed [ACC_W-1:0] q_sat;

    assign q_raw = acc_reg >>> FB;

    always_comb
    begin
        if (q_raw > Q_MAX)
        begin
            q_sat = Q_MAX;
        end
        else if (q_raw < Q_MIN)
        begin
            q_sat = Q_MIN;
        end
        else
        begin
            q_sat = q_raw;
        end
    end

    logic out_free;
    assign out_free = !out_valid_reg || !smp_stall;

    // ------------------------------------------------------------------
    // wave memory
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (wave_we)
        begin
            wave_mem[wr_addr] <= cmd_data.wave_value;
        end
        mem_q_reg <= wave_mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // sequencer, voice state and result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            attack_reg    <= 12'd0;
            sustain_reg   <= 12'd1;
            slot_reg      <= '0;
            phase_reg     <= 1'b0;
            voice_reg     <= '0;
            silent_reg    <= 1'b1;
            out_valid_reg <= 1'b0;
            for (int v = 0; v < VOICE_COUNT; v++)
            begin
                chan_reg[v]  <= 4'd0;
                key_reg[v]   <= 7'd0;
                vel_reg[v]   <= 7'd0;
                decay_reg[v] <= 9'd0;
                pos_reg[v]   <= 32'd0;
            end
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    wvm_pkg::REG_ATTACK:  attack_reg  <= cfg_data;
                    wvm_pkg::REG_SUSTAIN: sustain_reg <= cfg_data;
                    default: ;
                endcase
            end

            // drop the taken result unless a new one replaces it below
            if (out_valid_reg && !smp_stall && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end

            if (note_on)
            begin
                chan_reg[note_voice]  <= cmd_data.note_channel;
                key_reg[note_voice]   <= cmd_data.note_key;
                vel_reg[note_voice]   <= cmd_data.note_velocity;
                decay_reg[note_voice] <= 9'd0;
                pos_reg[note_voice]   <= 32'd0;
            end

            if (note_off)
            begin
                for (int v = 0; v < VOICE_COUNT; v++)
                begin
                    if (chan_reg[v] == cmd_data.note_channel
                        && key_reg[v] == cmd_data.note_key)
                    begin
                        vel_reg[v] <= 7'd0;
                    end
                end
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (smp_start)
                    begin
                        voice_reg  <= '0;
                        silent_reg <= 1'b1;
                        acc_reg    <= '0;
                        state_reg  <= S_READ;
                    end
                end

                S_READ:
                begin
                    // skip idle voices without the multiply and accumulate states
                    if (vel_reg[voice_reg] == 7'd0)
                    begin
                        if (voice_reg == LAST_VOICE)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            voice_reg <= voice_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        silent_reg <= 1'b0;
                        state_reg  <= S_MUL1;
                    end
                end

                S_MUL1:
                begin
                    prod_reg    <= mul_p;
                    pos_sum_reg <= pos_reg[voice_reg] + cur_step;
                    state_reg   <= S_MUL2;
                end

                S_MUL2:
                begin
                    prod_reg <= mul_p;
                    if (wrap)
                    begin
                        pos_reg[voice_reg]   <= pos_sum_reg - loop_len;
                        decay_reg[voice_reg] <= decay_nx;
                        if (decay_nx[8])
                        begin
                            vel_reg[voice_reg] <= 7'd0;
                        end
                    end
                    else
                    begin
                        pos_reg[voice_reg] <= pos_sum_reg;
                    end
                    state_reg <= S_ACC;
                end

                S_ACC:
                begin
                    acc_reg <= acc_reg + ACC_W'(prod_reg);
                    if (voice_reg == LAST_VOICE)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        voice_reg <= voice_reg + 1'b1;
                        state_reg <= S_READ;
                    end
                end

                S_DONE:
                begin
                    // hold until the result register is free
                    if (out_free)
                    begin
                        out_valid_reg             <= 1'b1;
                        out_data_reg.mixed_sample <= q_sat[8:0];
                        out_data_reg.silent       <= silent_reg;
                        if (slot_reg == LAST_SLOT)
                        begin
                            slot_reg  <= '0;
                            phase_reg <= !phase_reg;
                        end
                        else
                        begin
                            slot_reg <= slot_reg + 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign smp_valid = out_valid_reg;
    assign smp_data  = out_data_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    logic decay_ok;

    always_comb
    begin
        decay_ok = 1'b1;
        for (int v = 0; v < VOICE_COUNT; v++)
        begin
            if (vel_reg[v] != 7'd0 && decay_reg[v][8])
            begin
                decay_ok = 1'b0;
            end
        end
    end

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(smp_valid) |-> $past(state_reg == S_DONE))
        else $error("result raised without a finished mix");

    a_mul_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL2) |-> $past(state_reg == S_MUL1))
        else $error("second multiply pass without the first");

    a_active_decay: assert property (@(posedge clk) disable iff (!rst_n)
        decay_ok)
        else $error("active voice with decay past the fade table");

    a_new_mix_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(state_reg == S_IDLE) && state_reg == S_READ)
        |-> (acc_reg == '0 && voice_reg == '0))
        else $error("mix started without a cleared accumulator");

endmodule

`default_nettype wire
